/* design/msps_pkg.sv */
// ----------------------------------------------------------------------------
// msps_pkg
// Shared types and constants for the message slot prefix-match store.
// ----------------------------------------------------------------------------
package msps_pkg;

    // default geometry
    localparam int SLOTS_DEF     = 8;
    localparam int MSG_BYTES_DEF = 32;

    // field widths of one transaction
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 6;

    // readout never exceeds this many bytes
    localparam int READ_CAP = 32;

    // op codes
    localparam logic OP_STORE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MSG_WR,
        ST_PAT_CMP,
        ST_DONE,
        ST_RD_REQ,
        ST_RD_WAIT
    } t_state;

endpackage

/* design/msps_if.sv */
// ----------------------------------------------------------------------------
// msps_in_if / msps_out_if
// Valid/ready channels for input bytes and result transactions.
// ----------------------------------------------------------------------------
interface msps_in_if
    import msps_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              op;
    logic [BYTE_W-1:0] byte_value;
    logic              last_in;
    logic [LEN_W-1:0]  read_len;

    modport source (output valid, output op, output byte_value, output last_in,
                    output read_len, input ready);
    modport sink   (input valid, input op, input byte_value, input last_in,
                    input read_len, output ready);
endinterface

interface msps_out_if
    import msps_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              found;
    logic              dropped;
    logic              data_valid;
    logic [BYTE_W-1:0] data_byte;
    logic              last_out;

    modport source (output valid, output found, output dropped, output data_valid,
                    output data_byte, output last_out, input ready);
    modport sink   (input valid, input found, input dropped, input data_valid,
                    input data_byte, input last_out, output ready);
endinterface

/* design/message_slot_prefix_match_store_top.sv */
// ----------------------------------------------------------------------------
// message_slot_prefix_match_store_top
// Message slot store with prefix-match search and readout of the matched slot.
// ----------------------------------------------------------------------------
// The store holds SLOTS messages of up to MSG_BYTES bytes in one RAM laid out
// row by byte position: row p holds byte p of every slot, so a pattern byte
// is checked against all slots with a single read. Items are handled one at
// a time. A stored byte reads its row and then writes the merged row, or
// writes nothing when it is ignored or dropped; a pattern byte reads its
// row and is then compared, or past MSG_BYTES clears all matches unread.
// A final byte with a single result goes through ST_DONE to the output
// register; a match with data instead reads out min(read_len, MSG_BYTES,
// 32) bytes, each by a request (ST_RD_REQ) and a wait for the registered
// read data (ST_RD_WAIT). Either hand-off waits while the output register
// holds a result stalled downstream. After reset a clearing pass zeroes
// the RAM, one row per cycle, with ready held low. Results sit in an output
// register, so the next byte is taken while a result waits downstream.
// ----------------------------------------------------------------------------
module message_slot_prefix_match_store_top
    import msps_pkg::*;
#(
    parameter int SLOTS     = SLOTS_DEF,
    parameter int MSG_BYTES = MSG_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    msps_in_if.sink     i_in,
    msps_out_if.source  o_out
);

    // geometry
    localparam int SW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int AW      = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1;
    localparam int PW      = $clog2(MSG_BYTES + 1);
    localparam int IW      = (AW > LEN_W) ? AW : LEN_W;
    localparam int ROW_W   = SLOTS * BYTE_W;
    localparam int LEN_CAP = (MSG_BYTES < READ_CAP) ? MSG_BYTES : READ_CAP;

    localparam logic [PW-1:0]    POS_END  = PW'(MSG_BYTES);
    localparam logic [AW-1:0]    LAST_ROW = AW'(MSG_BYTES - 1);
    localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(LEN_CAP);

    t_state r_state, n_state;

    // message writer
    logic [SW-1:0] r_write_slot, n_write_slot;
    logic [PW-1:0] r_write_pos,  n_write_pos;
    logic          r_dropping,   n_dropping;

    // pattern search
    logic [PW-1:0]    r_pat_pos, n_pat_pos;
    logic [SLOTS-1:0] r_match,   n_match;

    // latched transaction
    logic [BYTE_W-1:0] r_byte, n_byte;
    logic              r_last, n_last;
    logic [LEN_W-1:0]  r_read_len, n_read_len;

    // single-result holding and readout
    logic              r_res_found, n_res_found;
    logic              r_res_dropped, n_res_dropped;
    logic [SW-1:0]     r_rd_slot, n_rd_slot;
    logic [LEN_W-1:0]  r_rd_len, n_rd_len;
    logic [LEN_W-1:0]  r_rd_idx, n_rd_idx;
    logic [AW-1:0]     r_clr_idx, n_clr_idx;

    // output register
    logic              r_o_valid, n_o_valid;
    logic              r_o_found, n_o_found;
    logic              r_o_dropped, n_o_dropped;
    logic              r_o_dv, n_o_dv;
    logic [BYTE_W-1:0] r_o_byte, n_o_byte;
    logic              r_o_last, n_o_last;

    // RAM port
    logic             ram_wr_en;
    logic [AW-1:0]    ram_wr_addr;
    logic [ROW_W-1:0] ram_wr_data;
    logic             ram_rd_en;
    logic [AW-1:0]    ram_rd_addr;
    logic [ROW_W-1:0] ram_rd_data;

    // occupancy
    logic             occ_set_en, occ_clr_en;
    logic [SW-1:0]    occ_set_idx, occ_clr_idx;
    logic [SLOTS-1:0] cand_mask;
    logic             free_found, cand_found;
    logic [SW-1:0]    free_idx, cand_idx;

    // helpers
    logic             in_acc;
    logic             out_free;
    logic             write_pos_lt;
    logic             pat_pos_lt;
    logic             drop_now;
    logic [SW-1:0]    slot_now;
    logic [SLOTS-1:0] eq_mask;
    logic [SLOTS-1:0] mask_new;
    logic [LEN_W-1:0] len_cut;
    logic             rd_last;
    logic [IW-1:0]    rd_idx_ext;

    assign in_acc       = i_in.valid && i_in.ready;
    assign out_free     = !r_o_valid || o_out.ready;
    assign write_pos_lt = (r_write_pos < POS_END);
    assign pat_pos_lt   = (r_pat_pos < POS_END);

    // slot choice is made on the first byte of a message
    assign drop_now = (r_write_pos == '0) ? !free_found : r_dropping;
    assign slot_now = (r_write_pos == '0) ? free_idx : r_write_slot;

    always_comb begin
        for (int s = 0; s < SLOTS; s++) begin
            eq_mask[s] = (ram_rd_data[s*BYTE_W +: BYTE_W] == r_byte);
        end
    end

    assign mask_new   = r_match & eq_mask;
    assign cand_mask  = mask_new;
    assign len_cut    = (r_read_len > LEN_MAX) ? LEN_MAX : r_read_len;
    assign rd_last    = (LEN_W'(r_rd_idx + LEN_W'(1)) == r_rd_len);
    assign rd_idx_ext = IW'(r_rd_idx);

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_idx == LAST_ROW) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_in.op == OP_STORE) begin
                        if (write_pos_lt && !drop_now) begin
                            n_state = ST_MSG_WR;
                        end else if (i_in.last_in) begin
                            n_state = ST_DONE;
                        end
                    end else begin
                        if (pat_pos_lt) begin
                            n_state = ST_PAT_CMP;
                        end else if (i_in.last_in) begin
                            n_state = ST_DONE;
                        end
                    end
                end
            end
            ST_MSG_WR: begin
                n_state = r_last ? ST_DONE : ST_IDLE;
            end
            ST_PAT_CMP: begin
                if (!r_last) begin
                    n_state = ST_IDLE;
                end else if (cand_found && (len_cut != '0)) begin
                    n_state = ST_RD_REQ;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_RD_REQ: begin
                n_state = ST_RD_WAIT;
            end
            ST_RD_WAIT: begin
                if (out_free) begin
                    n_state = rd_last ? ST_IDLE : ST_RD_REQ;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // ------------------------------------------------------------------
    // datapath and outputs
    // ------------------------------------------------------------------
    always_comb begin
        n_write_slot  = r_write_slot;
        n_write_pos   = r_write_pos;
        n_dropping    = r_dropping;
        n_pat_pos     = r_pat_pos;
        n_match       = r_match;
        n_byte        = r_byte;
        n_last        = r_last;
        n_read_len    = r_read_len;
        n_res_found   = r_res_found;
        n_res_dropped = r_res_dropped;
        n_rd_slot     = r_rd_slot;
        n_rd_len      = r_rd_len;
        n_rd_idx      = r_rd_idx;
        n_clr_idx     = r_clr_idx;

        n_o_valid   = r_o_valid && !o_out.ready;
        n_o_found   = r_o_found;
        n_o_dropped = r_o_dropped;
        n_o_dv      = r_o_dv;
        n_o_byte    = r_o_byte;
        n_o_last    = r_o_last;

        ram_wr_en   = 1'b0;
        ram_wr_addr = r_write_pos[AW-1:0];
        ram_wr_data = ram_rd_data;
        ram_rd_en   = 1'b0;
        ram_rd_addr = r_write_pos[AW-1:0];

        occ_set_en  = 1'b0;
        occ_set_idx = slot_now;
        occ_clr_en  = 1'b0;
        occ_clr_idx = cand_idx;

        unique case (r_state)
            ST_CLEAR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_clr_idx;
                ram_wr_data = '0;
                n_clr_idx   = AW'(r_clr_idx + AW'(1));
            end
            ST_IDLE: begin
                if (in_acc) begin
                    n_byte     = i_in.byte_value;
                    n_last     = i_in.last_in;
                    n_read_len = i_in.read_len;
                    if (i_in.op == OP_STORE) begin
                        n_write_slot = slot_now;
                        n_dropping   = drop_now;
                        if (write_pos_lt && !drop_now) begin
                            // fetch the row, merge the byte next cycle
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = r_write_pos[AW-1:0];
                        end else begin
                            if (write_pos_lt) begin
                                n_write_pos = PW'(r_write_pos + PW'(1));
                            end
                            if (i_in.last_in) begin
                                occ_set_en    = !drop_now;
                                occ_set_idx   = slot_now;
                                n_res_found   = 1'b0;
                                n_res_dropped = drop_now;
                                n_write_pos   = '0;
                                n_dropping    = 1'b0;
                            end
                        end
                    end else begin
                        if (pat_pos_lt) begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = r_pat_pos[AW-1:0];
                        end else begin
                            // pattern longer than a slot: nothing can match
                            n_match = '0;
                            if (i_in.last_in) begin
                                n_res_found   = 1'b0;
                                n_res_dropped = 1'b0;
                                n_pat_pos     = '0;
                                n_match       = '1;
                            end
                        end
                    end
                end
            end
            ST_MSG_WR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_write_pos[AW-1:0];
                for (int s = 0; s < SLOTS; s++) begin
                    if (SW'(s) == r_write_slot) begin
                        ram_wr_data[s*BYTE_W +: BYTE_W] = r_byte;
                    end
                end
                n_write_pos = PW'(r_write_pos + PW'(1));
                if (r_last) begin
                    occ_set_en    = 1'b1;
                    occ_set_idx   = r_write_slot;
                    n_res_found   = 1'b0;
                    n_res_dropped = 1'b0;
                    n_write_pos   = '0;
                    n_dropping    = 1'b0;
                end
            end
            ST_PAT_CMP: begin
                n_match   = mask_new;
                n_pat_pos = PW'(r_pat_pos + PW'(1));
                if (r_last) begin
                    n_pat_pos     = '0;
                    n_match       = '1;
                    n_res_dropped = 1'b0;
                    n_res_found   = cand_found;
                    occ_clr_en    = cand_found;
                    occ_clr_idx   = cand_idx;
                    n_rd_slot     = cand_idx;
                    n_rd_len      = len_cut;
                    n_rd_idx      = '0;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_o_valid   = 1'b1;
                    n_o_found   = r_res_found;
                    n_o_dropped = r_res_dropped;
                    n_o_dv      = 1'b0;
                    n_o_byte    = '0;
                    n_o_last    = 1'b1;
                end
            end
            ST_RD_REQ: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = rd_idx_ext[AW-1:0];
            end
            ST_RD_WAIT: begin
                if (out_free) begin
                    n_o_valid   = 1'b1;
                    n_o_found   = 1'b1;
                    n_o_dropped = 1'b0;
                    n_o_dv      = 1'b1;
                    n_o_byte    = ram_rd_data[int'(r_rd_slot)*BYTE_W +: BYTE_W];
                    n_o_last    = rd_last;
                    n_rd_idx    = LEN_W'(r_rd_idx + LEN_W'(1));
                end
            end
            default: begin
                n_o_valid = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_write_slot <= '0;
            r_write_pos  <= '0;
            r_dropping   <= 1'b0;
            r_pat_pos    <= '0;
            r_match      <= '1;
            r_clr_idx    <= '0;
            r_rd_idx     <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_write_slot <= n_write_slot;
            r_write_pos  <= n_write_pos;
            r_dropping   <= n_dropping;
            r_pat_pos    <= n_pat_pos;
            r_match      <= n_match;
            r_clr_idx    <= n_clr_idx;
            r_rd_idx     <= n_rd_idx;
            r_o_valid    <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte        <= n_byte;
        r_last        <= n_last;
        r_read_len    <= n_read_len;
        r_res_found   <= n_res_found;
        r_res_dropped <= n_res_dropped;
        r_rd_slot     <= n_rd_slot;
        r_rd_len      <= n_rd_len;
        r_o_found     <= n_o_found;
        r_o_dropped   <= n_o_dropped;
        r_o_dv        <= n_o_dv;
        r_o_byte      <= n_o_byte;
        r_o_last      <= n_o_last;
    end

    // ------------------------------------------------------------------
    // submodules
    // ------------------------------------------------------------------
    msps_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MSG_BYTES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    msps_occ #(
        .SLOTS (SLOTS)
    ) u_occ (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_set_en     (occ_set_en),
        .i_set_idx    (occ_set_idx),
        .i_clr_en     (occ_clr_en),
        .i_clr_idx    (occ_clr_idx),
        .i_cand_mask  (cand_mask),
        .o_free_found (free_found),
        .o_free_idx   (free_idx),
        .o_cand_found (cand_found),
        .o_cand_idx   (cand_idx)
    );

    // ports
    assign i_in.ready       = (r_state == ST_IDLE);
    assign o_out.valid      = r_o_valid;
    assign o_out.found      = r_o_found;
    assign o_out.dropped    = r_o_dropped;
    assign o_out.data_valid = r_o_dv;
    assign o_out.data_byte  = r_o_byte;
    assign o_out.last_out   = r_o_last;

endmodule

/* design/msps_ram.sv */
// ----------------------------------------------------------------------------
// msps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module msps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* design/msps_occ.sv */
// ----------------------------------------------------------------------------
// msps_occ
// Slot occupancy flags with lowest-free and lowest-candidate encoders.
// ----------------------------------------------------------------------------
module msps_occ #(
    parameter int SLOTS = 8,
    localparam int SW   = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_set_en,
    input  logic [SW-1:0]    i_set_idx,
    input  logic             i_clr_en,
    input  logic [SW-1:0]    i_clr_idx,
    input  logic [SLOTS-1:0] i_cand_mask,
    output logic             o_free_found,
    output logic [SW-1:0]    o_free_idx,
    output logic             o_cand_found,
    output logic [SW-1:0]    o_cand_idx
);

    logic [SLOTS-1:0] r_used;
    logic [SLOTS-1:0] n_used;
    logic [SLOTS-1:0] cand;

    always_comb begin
        n_used = r_used;
        if (i_set_en) begin
            n_used[i_set_idx] = 1'b1;
        end
        if (i_clr_en) begin
            n_used[i_clr_idx] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else begin
            r_used <= n_used;
        end
    end

    assign cand = i_cand_mask & r_used;

    // priority encoders, lowest index wins
    always_comb begin
        o_free_found = 1'b0;
        o_free_idx   = '0;
        o_cand_found = 1'b0;
        o_cand_idx   = '0;
        for (int s = SLOTS - 1; s >= 0; s--) begin
            if (!r_used[s]) begin
                o_free_found = 1'b1;
                o_free_idx   = SW'(s);
            end
            if (cand[s]) begin
                o_cand_found = 1'b1;
                o_cand_idx   = SW'(s);
            end
        end
    end

endmodule

/* design/msps_chk.sv */
// ----------------------------------------------------------------------------
// msps_chk
// Port-level checks on result transactions, bound to the top level.
// ----------------------------------------------------------------------------
module msps_chk
    import msps_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic              i_found,
    input logic              i_dropped,
    input logic              i_data_valid,
    input logic [BYTE_W-1:0] i_data_byte,
    input logic              i_last_out
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_data_byte)
        && $stable(i_last_out) && $stable(i_found))
        else $error("result changed while stalled");

    // clearing pass follows reset: no byte taken right after it
    a_clear_after_rst: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !i_in_ready)
        else $error("input ready during clearing pass");

    // readout bytes belong to a match
    a_data_is_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_data_valid |-> i_found && !i_dropped)
        else $error("data byte without match");

    // a result without data is a single final one with a zero byte
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_data_valid |-> i_last_out && (i_data_byte == '0)
        && !(i_found && i_dropped))
        else $error("malformed single result");

endmodule

bind message_slot_prefix_match_store_top msps_chk u_msps_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_found      (o_out.found),
    .i_dropped    (o_out.dropped),
    .i_data_valid (o_out.data_valid),
    .i_data_byte  (o_out.data_byte),
    .i_last_out   (o_out.last_out)
);
